>>> rtl/assert_macros.svh
// assertion macros used by the reverse calendar clock back module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rcc_pkg.sv
// shared types, constants and calendar helpers for the reverse calendar clock
package rcc_pkg;

  // field widths
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned CENT_W  = 7;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;

  // limits and reset values
  localparam logic [SEC_W-1:0]   MAX_BACK  = 6'd60;
  localparam logic [SEC_W-1:0]   LAST_SEC  = 6'd59;
  localparam logic [MIN_W-1:0]   LAST_MIN  = 6'd59;
  localparam logic [HOUR_W-1:0]  LAST_HOUR = 5'd23;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_TOP  = 14'd9999;
  localparam logic [CENT_W-1:0]  LAST_TWO_DIGITS = 7'd99;

  localparam logic [HOUR_W-1:0]  RST_HOUR  = 5'd12;
  localparam logic [MIN_W-1:0]   RST_MIN   = 6'd0;
  localparam logic [SEC_W-1:0]   RST_SEC   = 6'd0;
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd4;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd9;
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2026;
  localparam logic [CENT_W-1:0]  RST_YEAR_HI = 7'd20;
  localparam logic [CENT_W-1:0]  RST_YEAR_LO = 7'd26;

  localparam logic [HOUR_W-1:0]  RST_ALARM_HOUR = 5'd11;
  localparam logic [MIN_W-1:0]   RST_ALARM_MIN  = 6'd55;
  localparam logic [SEC_W-1:0]   RST_ALARM_SEC  = 6'd0;

  // item kinds
  typedef enum logic {
    OP_SECONDS = 1'b0,
    OP_DAY     = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_HOUR   = 2'd0,
    CFG_ALARM_MINUTE = 2'd1,
    CFG_ALARM_SECOND = 2'd2,
    CFG_ALARM_ENABLE = 2'd3
  } cfg_idx_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t              op;
    logic [SEC_W-1:0] secs;
  } cmd_t;

  // days in a month, leap flag picks february length
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                   d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/rcc_front.sv
// input side: accepts items, saturates the step and queues commands
module rcc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [rcc_pkg::IN_DATA_W-1:0] s_tdata,  // [5:0] seconds_back, rest zero
  input  logic                       s_tuser,   // [0] op
  output logic                       cmd_valid,
  output rcc_pkg::cmd_t              cmd,
  input  logic                       cmd_pop
);
  import rcc_pkg::*;

  cmd_t             queue [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  cmd_t             cmd_in;
  logic [SEC_W-1:0] secs_in;

  // classify the incoming transfer, clamp the step to one minute
  always_comb begin
    secs_in = s_tdata[SEC_W-1:0];
    if (secs_in > MAX_BACK) begin
      secs_in = MAX_BACK;
    end
    cmd_in.op   = op_t'(s_tuser);
    cmd_in.secs = secs_in;
  end

  assign s_tready  = (count != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/rcc_back.sv
// clock side: holds time, date and alarm, applies commands, drives results
module rcc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rcc_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           cmd_valid,
  input  rcc_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rcc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser
);
  import rcc_pkg::*;

  `include "assert_macros.svh"

  // alarm configuration
  logic [HOUR_W-1:0] alarm_hour;
  logic [MIN_W-1:0]  alarm_minute;
  logic [SEC_W-1:0]  alarm_second;
  logic              alarm_enable;

  // clock state
  logic [HOUR_W-1:0]  hour_now,   hour_next;
  logic [MIN_W-1:0]   minute_now, minute_next;
  logic [SEC_W-1:0]   second_now, second_next;
  logic [DAY_W-1:0]   day_now,    day_next;
  logic [MONTH_W-1:0] month_now,  month_next;
  logic [YEAR_W-1:0]  year_now,   year_next;
  logic [CENT_W-1:0]  year_hi,    year_hi_next;
  logic [CENT_W-1:0]  year_lo,    year_lo_next;
  logic               alarm_fired;
  logic               hit_next;

  logic               sec_borrow;
  logic               day_borrow;
  logic               leap_now;
  logic [SEC_W:0]     sec_wrap;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_hour   <= RST_ALARM_HOUR;
      alarm_minute <= RST_ALARM_MIN;
      alarm_second <= RST_ALARM_SEC;
      alarm_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ALARM_HOUR:   alarm_hour   <= cfg_wdata[HOUR_W-1:0];
        CFG_ALARM_MINUTE: alarm_minute <= cfg_wdata[MIN_W-1:0];
        CFG_ALARM_SECOND: alarm_second <= cfg_wdata[SEC_W-1:0];
        CFG_ALARM_ENABLE: alarm_enable <= cfg_wdata[0];
        default:          alarm_enable <= alarm_enable;
      endcase
    end
  end

  // take a command whenever the output register is free or draining
  assign cmd_pop = cmd_valid && (!m_tvalid || m_tready);

  // leap rule on the split year: century years use the upper two digits
  assign leap_now = (year_lo == '0) ? (year_hi[1:0] == 2'd0) : (year_lo[1:0] == 2'd0);

  // borrow chain for one command
  always_comb begin
    hour_next    = hour_now;
    minute_next  = minute_now;
    second_next  = second_now;
    day_next     = day_now;
    month_next   = month_now;
    year_next    = year_now;
    year_hi_next = year_hi;
    year_lo_next = year_lo;
    hit_next     = 1'b0;

    sec_borrow = (cmd.op == OP_SECONDS) && (second_now < cmd.secs);
    sec_wrap   = {1'b0, second_now} + 7'd60 - {1'b0, cmd.secs};
    day_borrow = (cmd.op == OP_DAY) ||
                 (sec_borrow && (minute_now == '0) && (hour_now == '0));

    // seconds, minutes, hours
    if (cmd.op == OP_SECONDS) begin
      if (!sec_borrow) begin
        second_next = second_now - cmd.secs;
      end else begin
        second_next = sec_wrap[SEC_W-1:0];
        if (minute_now != '0) begin
          minute_next = minute_now - 6'd1;
        end else begin
          minute_next = LAST_MIN;
          if (hour_now != '0) begin
            hour_next = hour_now - 5'd1;
          end else begin
            hour_next = LAST_HOUR;
          end
        end
      end
    end

    // day, month, year
    if (day_borrow) begin
      if (day_now > 5'd1) begin
        day_next = day_now - 5'd1;
      end else begin
        if (month_now > 4'd1) begin
          month_next = month_now - 4'd1;
        end else begin
          month_next = LAST_MONTH;
          if (year_now == '0) begin
            year_next    = YEAR_TOP;
            year_hi_next = LAST_TWO_DIGITS;
            year_lo_next = LAST_TWO_DIGITS;
          end else begin
            year_next = year_now - 14'd1;
            if (year_lo == '0) begin
              year_lo_next = LAST_TWO_DIGITS;
              year_hi_next = year_hi - 7'd1;
            end else begin
              year_lo_next = year_lo - 7'd1;
            end
          end
        end
        // february is only reached from march, so the year is unchanged there
        day_next = month_days(month_next, leap_now);
      end
    end

    // alarm check after a seconds step
    if ((cmd.op == OP_SECONDS) && alarm_enable && !alarm_fired &&
        (hour_next == alarm_hour) && (minute_next == alarm_minute) &&
        (second_next == alarm_second)) begin
      hit_next = 1'b1;
    end
  end

  // clock state update
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_now    <= RST_HOUR;
      minute_now  <= RST_MIN;
      second_now  <= RST_SEC;
      day_now     <= RST_DAY;
      month_now   <= RST_MONTH;
      year_now    <= RST_YEAR;
      year_hi     <= RST_YEAR_HI;
      year_lo     <= RST_YEAR_LO;
      alarm_fired <= 1'b0;
    end else if (cmd_pop) begin
      hour_now    <= hour_next;
      minute_now  <= minute_next;
      second_now  <= second_next;
      day_now     <= day_next;
      month_now   <= month_next;
      year_now    <= year_next;
      year_hi     <= year_hi_next;
      year_lo     <= year_lo_next;
      if (hit_next) begin
        alarm_fired <= 1'b1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      m_tdata <= {second_next, minute_next, hour_next, year_next, month_next, day_next};
      m_tuser <= hit_next;
    end
  end

  `RCC_ASSERT_NEXT(a_latch_holds, alarm_fired, alarm_fired, "alarm latch cleared")
  `RCC_ASSERT(a_hit_sets_latch, !(m_tvalid && m_tuser) || alarm_fired,
              "alarm hit shown without latch set")
  `RCC_ASSERT(a_time_range, (second_now <= LAST_SEC) && (minute_now <= LAST_MIN) &&
              (hour_now <= LAST_HOUR), "time of day out of range")
  `RCC_ASSERT(a_date_range, (day_now != '0) && (month_now != '0) &&
              (month_now <= LAST_MONTH) && (year_now <= YEAR_TOP), "date out of range")

endmodule

>>> rtl/reverse_calendar_clock_top.sv
// top level of the reverse calendar clock
//
// Input channel s_*: one transfer per item. s_tuser is the op (0 steps the
// time back by s_tdata[5:0] seconds, values above 60 count as 60; 1 steps
// the date back one day). Output channel m_*: one result transfer per item
// with the date and time after the step and, in m_tuser, the alarm hit.
// Config: cfg_we writes cfg_wdata into the register cfg_addr picks
// (0 alarm hour, 1 alarm minute, 2 alarm second, 3 alarm enable); write
// only while no item is in flight.
// A result passes through the command queue and then the output register.
// Throughput: one item per cycle while m_tready stays high; the whole borrow
// chain and the alarm compare are combinational in the back stage.
// A two-entry command queue separates the input and output sides, so input
// keeps flowing while a result waits. If m_tready stays low the result is
// held, the queue fills and s_tready drops after two more items.
// Reset (rst, synchronous): 12:00:00 on 4 September 2026, alarm at 11:55:00
// enabled and not fired, queue and output empty.
module reverse_calendar_clock_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rcc_pkg::IN_DATA_W-1:0]  s_tdata,   // [5:0] seconds_back, [7:6] zero
  input  logic                           s_tuser,   // [0] op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [4:0] day_out, [8:5] month_out, [22:9] year_out, [27:23] hour_out,
  // [33:28] minute_out, [39:34] second_out
  output logic [rcc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser,   // [0] alarm_hit
  input  logic                           cfg_we,
  input  logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rcc_pkg::CFG_W-1:0]      cfg_wdata
);
  import rcc_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // accept and queue
  rcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // clock state and result register
  rcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

>>> bench/testbench.sv
// self-checking bench for the backward-counting calendar clock with its one-shot alarm
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rcc_pkg::*;

  localparam int QUIET_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RAND_PHASES    = 5;
  localparam int ITEMS_PER_PASS = 150;
  localparam int DAY_RUN        = 950;
  localparam int GAP_PERCENT    = 36;
  localparam int SCRIPT_ROWS    = 19;

  // date and time carried by one result transfer
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               hit;
  } clock_stamp_t;

  // one line of the directed script: an item or a register write
  typedef struct packed {
    logic         is_cfg;
    op_t          op;
    logic [5:0]   arg;
    cfg_idx_t     reg_idx;
    logic         typed;
    clock_stamp_t want;
  } script_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  reverse_calendar_clock_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // predicted clock state and alarm registers
  logic [YEAR_W-1:0]  cal_year;
  logic [MONTH_W-1:0] cal_month;
  logic [DAY_W-1:0]   cal_day;
  logic [HOUR_W-1:0]  cal_hour;
  logic [MIN_W-1:0]   cal_minute;
  logic [SEC_W-1:0]   cal_second;
  logic               alarm_latched;
  logic [HOUR_W-1:0]  alarm_hr;
  logic [MIN_W-1:0]   alarm_min;
  logic [SEC_W-1:0]   alarm_sec;
  logic               alarm_on;

  clock_stamp_t expected_stamps[$];
  script_row_t  script [SCRIPT_ROWS];
  int           fail_count = 0;
  int           quiet_cycles = 0;
  int           hold_left = 0;
  bit           hold_off_req = 1'b0;
  bit           full_rate = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // days in a month of a given year, leap rule included
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic [YEAR_W-1:0] y);
    logic leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    if (m == 4'd2)
      return leap ? 5'd29 : 5'd28;
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
      return 5'd30;
    return 5'd31;
  endfunction

  // one day back, through month and year borrows
  function automatic void back_a_day();
    if (cal_day > 5'd1) begin
      cal_day = cal_day - 5'd1;
    end else begin
      if (cal_month > 4'd1) begin
        cal_month = cal_month - 4'd1;
      end else begin
        cal_month = 4'd12;
        cal_year = (cal_year == 14'd0) ? 14'd9999 : cal_year - 14'd1;
      end
      cal_day = month_length(cal_month, cal_year);
    end
  endfunction

  // predicted result of one accepted item, state advanced
  function automatic clock_stamp_t rewind(input op_t op, input logic [SEC_W-1:0] secs);
    int unsigned  n;
    logic         hit;
    clock_stamp_t r;
    hit = 1'b0;
    if (op == OP_DAY) begin
      back_a_day();
    end else begin
      // more than a minute counts as one minute
      n = (secs > 6'd60) ? 60 : secs;
      if (cal_second >= n) begin
        cal_second = SEC_W'(cal_second - n);
      end else begin
        cal_second = SEC_W'(cal_second + 60 - n);
        if (cal_minute != 6'd0) begin
          cal_minute = cal_minute - 6'd1;
        end else begin
          cal_minute = 6'd59;
          if (cal_hour != 5'd0) begin
            cal_hour = cal_hour - 5'd1;
          end else begin
            cal_hour = 5'd23;
            back_a_day();
          end
        end
      end
      // alarm fires once per run
      if (alarm_on && !alarm_latched && cal_hour == alarm_hr &&
          cal_minute == alarm_min && cal_second == alarm_sec) begin
        alarm_latched = 1'b1;
        hit = 1'b1;
      end
    end
    r.year = cal_year;
    r.month = cal_month;
    r.day = cal_day;
    r.hour = cal_hour;
    r.minute = cal_minute;
    r.second = cal_second;
    r.hit = hit;
    return r;
  endfunction

  function automatic string stamp_text(input clock_stamp_t t);
    return $sformatf("%04d-%02d-%02d %02d:%02d:%02d hit=%0d",
                     t.year, t.month, t.day, t.hour, t.minute, t.second, t.hit);
  endfunction

  // script row builders
  function automatic script_row_t step_row(input op_t op, input logic [5:0] secs);
    script_row_t row;
    row = '0;
    row.op = op;
    row.arg = secs;
    return row;
  endfunction

  function automatic script_row_t check_row(input op_t op, input logic [5:0] secs,
                                            input int y, input int mo, input int d,
                                            input int h, input int mi, input int s,
                                            input logic hit);
    script_row_t row;
    row = step_row(op, secs);
    row.typed = 1'b1;
    row.want.year = YEAR_W'(y);
    row.want.month = MONTH_W'(mo);
    row.want.day = DAY_W'(d);
    row.want.hour = HOUR_W'(h);
    row.want.minute = MIN_W'(mi);
    row.want.second = SEC_W'(s);
    row.want.hit = hit;
    return row;
  endfunction

  function automatic script_row_t reg_row(input cfg_idx_t idx, input logic [5:0] value);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.arg = value;
    return row;
  endfunction

  // offer one item, wait for its transfer, queue what it should produce
  task automatic send_step(input op_t op, input logic [SEC_W-1:0] secs,
                           input logic typed, input clock_stamp_t want);
    clock_stamp_t predicted;
    if (!full_rate) begin
      while ($urandom_range(99) < GAP_PERCENT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= IN_DATA_W'(secs);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = rewind(op, secs);
    expected_stamps.push_back(typed ? want : predicted);
  endtask

  // stop offering and let every pending result come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write on an idle block
  task automatic write_alarm_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ALARM_HOUR:   alarm_hr = value[HOUR_W-1:0];
      CFG_ALARM_MINUTE: alarm_min = value[MIN_W-1:0];
      CFG_ALARM_SECOND: alarm_sec = value[SEC_W-1:0];
      CFG_ALARM_ENABLE: alarm_on = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side: check each transfer, then pick next ready
  always @(posedge clk) begin : result_check
    clock_stamp_t got;
    clock_stamp_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.day = m_tdata[4:0];
      got.month = m_tdata[8:5];
      got.year = m_tdata[22:9];
      got.hour = m_tdata[27:23];
      got.minute = m_tdata[33:28];
      got.second = m_tdata[39:34];
      got.hit = m_tuser;
      if (expected_stamps.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result %s", stamp_text(got));
      end else begin
        want = expected_stamps.pop_front();
        if (got.year !== want.year || got.month !== want.month ||
            got.day !== want.day || got.hour !== want.hour ||
            got.minute !== want.minute || got.second !== want.second ||
            got.hit !== want.hit) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %s, got %s", stamp_text(want), stamp_text(got));
        end
      end
    end
    // long hold-off so the input side backs up
    if (hold_off_req) begin
      hold_left = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= full_rate || ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [CFG_W-1:0] hr_val, min_val, sec_val, en_val;
    int pick;

    cal_year = 14'd2026;
    cal_month = 4'd9;
    cal_day = 5'd4;
    cal_hour = 5'd12;
    cal_minute = 6'd0;
    cal_second = 6'd0;
    alarm_latched = 1'b0;
    alarm_hr = 5'd11;
    alarm_min = 6'd55;
    alarm_sec = 6'd0;
    alarm_on = 1'b1;

    // directed script: saturation, borrows, alarm gating, one-shot latch, month borrow
    script = '{
      check_row(OP_SECONDS, 6'd0,  2026, 9, 4, 12, 0, 0, 1'b0),
      check_row(OP_SECONDS, 6'd63, 2026, 9, 4, 11, 59, 0, 1'b0),
      step_row(OP_SECONDS, 6'd62),
      step_row(OP_SECONDS, 6'd61),
      reg_row(CFG_ALARM_ENABLE, 6'd0),
      step_row(OP_SECONDS, 6'd60),
      check_row(OP_SECONDS, 6'd60, 2026, 9, 4, 11, 55, 0, 1'b0),
      reg_row(CFG_ALARM_ENABLE, 6'd1),
      check_row(OP_SECONDS, 6'd0,  2026, 9, 4, 11, 55, 0, 1'b1),
      check_row(OP_SECONDS, 6'd0,  2026, 9, 4, 11, 55, 0, 1'b0),
      step_row(OP_SECONDS, 6'd1),
      step_row(OP_SECONDS, 6'd59),
      step_row(OP_SECONDS, 6'd32),
      step_row(OP_SECONDS, 6'd31),
      step_row(OP_DAY, 6'd45),
      step_row(OP_DAY, 6'd0),
      step_row(OP_DAY, 6'd63),
      check_row(OP_DAY, 6'd18, 2026, 8, 31, 11, 52, 57, 1'b0),
      step_row(OP_SECONDS, 6'd57)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg)
        write_alarm_reg(script[i].reg_idx, script[i].arg);
      else
        send_step(script[i].op, script[i].arg, script[i].typed, script[i].want);
    end

    // back-to-back day jumps through month and year borrows, down past a leap february
    full_rate = 1'b1;
    repeat (DAY_RUN) send_step(OP_DAY, SEC_W'($urandom), 1'b0, '0);
    full_rate = 1'b0;

    // random passes, each with its own alarm setting
    for (int pass = 0; pass < RAND_PHASES; pass++) begin
      case (pass)
        0: begin
          hr_val = 6'h3F; min_val = 6'h3F; sec_val = 6'h3F; en_val = 6'h01;
        end
        1: begin
          hr_val = 6'h00; min_val = 6'h00; sec_val = 6'h00; en_val = 6'h3E;
        end
        default: begin
          hr_val = CFG_W'($urandom_range(63));
          min_val = CFG_W'($urandom_range(63));
          sec_val = CFG_W'($urandom_range(63));
          en_val = CFG_W'($urandom_range(63));
        end
      endcase
      write_alarm_reg(CFG_ALARM_HOUR, hr_val);
      write_alarm_reg(CFG_ALARM_MINUTE, min_val);
      write_alarm_reg(CFG_ALARM_SECOND, sec_val);
      write_alarm_reg(CFG_ALARM_ENABLE, en_val);
      if (pass == 1)
        hold_off_req = 1'b1;
      repeat (ITEMS_PER_PASS) begin
        pick = $urandom_range(99);
        // mostly large steps so the time runs back quickly
        if (pick < 10)
          send_step(OP_DAY, SEC_W'($urandom), 1'b0, '0);
        else if (pick < 55)
          send_step(OP_SECONDS, SEC_W'($urandom_range(63)), 1'b0, '0);
        else
          send_step(OP_SECONDS, SEC_W'($urandom_range(63, 50)), 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0 && expected_stamps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rcc_pkg.sv
rtl/rcc_front.sv
rtl/rcc_back.sv
rtl/reverse_calendar_clock_top.sv
bench/testbench.sv
